// ===== hdl/tie_pkg.sv =====
// Package for the prefix tree insert engine.
// Holds the item and result types and the item kind codes; no dependencies.
package tie_pkg;

  localparam int unsigned KindW = 2;
  localparam int unsigned LetterW = 5;
  localparam int unsigned NodeIdxW = 10;

  localparam logic [KindW-1:0] KindLetter = 2'd0;
  localparam logic [KindW-1:0] KindEnd = 2'd1;
  localparam logic [KindW-1:0] KindClear = 2'd2;

  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic [LetterW-1:0] letter;
  } tie_in_t;

  typedef struct packed {
    logic [NodeIdxW-1:0] node_index;
    logic                created;
    logic                pool_full;
    logic                already_word;
  } tie_out_t;

endpackage

// ===== hdl/tie_stream_if.sv =====
// Valid/ready stream interface for the prefix tree insert engine.
// The payload type is a parameter; used with the structs of tie_pkg.
interface tie_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/trie_insert_engine_core.sv =====
// Prefix tree insert engine: top level with the node and link memories.
// Depends on tie_pkg, tie_stream_if and tie_ram.
module trie_insert_engine_core #(
  parameter int unsigned POOL_NODES = 1024,
  parameter int unsigned ALPHABET_SIZE = 26
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  tie_stream_if.sink                     in_i,
  tie_stream_if.source                   out_o
);
  // Builds a prefix tree over an alphabet of ALPHABET_SIZE letters in a pool of
  // POOL_NODES nodes, node 0 being the root. Each input transfer yields exactly
  // one result transfer. A letter follows the current node's child link, or
  // takes the next free node and links it in, then moves to the child; an end
  // item marks the current node as a word end and returns to the root; a clear
  // item frees the pool. When the pool runs out the word in progress is dropped:
  // pool_full is raised and its end item marks nothing. Letters at or above
  // ALPHABET_SIZE and kind three are ignored and report the current node.
  // Flow: an item passes through idle, where the input transfer launches the
  // reads of the node and link memories, and the update state, where it updates
  // them and loads the result into the output register. A letter that allocates
  // a node also passes through the init state, which clears the fresh node's
  // entry through the single write port of the node memory. The next item is
  // taken once the engine is back in idle, even while the previous result still
  // waits in the output register; that item then holds in its update cycle until
  // the waiting result leaves. No clearing pass is needed after reset: the root's
  // entry is cleared by a flag and every other node entry is written when its
  // node is allocated.
  import tie_pkg::*;

  localparam int unsigned NodeW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int unsigned UsedW = NodeW + 1;
  localparam int unsigned LinkDepth = POOL_NODES * ALPHABET_SIZE;
  localparam int unsigned LinkAw = $clog2(LinkDepth);
  localparam int unsigned NodeWordW = ALPHABET_SIZE + 1;  // child bits, then word end
  localparam int unsigned CmpW = 7;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_INIT = 2'd2;

  logic [1:0]             state_q, state_d;
  logic [NodeW-1:0]       cur_q, cur_d;
  logic [UsedW-1:0]       used_q, used_d;
  logic                   failed_q, failed_d;
  logic                   root_valid_q, root_valid_d;
  logic                   out_valid_q, out_valid_d;
  tie_out_t               out_q, out_d;

  // Item fields captured at the input transfer
  logic [KindW-1:0]       kind_q;
  logic [LetterW-1:0]     letter_q;
  logic                   letter_ok_q;
  logic [LinkAw-1:0]      slot_q;

  logic                   in_xfer;
  logic                   letter_ok;
  logic [LetterW-1:0]     letter_sel;
  logic [LinkAw-1:0]      slot;
  logic                   exec_go;

  logic                   node_we;
  logic [NodeW-1:0]       node_waddr;
  logic [NodeWordW-1:0]   node_wdata;
  logic [NodeWordW-1:0]   node_rdata;
  logic [NodeWordW-1:0]   node_word;
  logic                   link_we;
  logic [NodeW-1:0]       link_rdata;
  logic [NodeW-1:0]       fresh;
  logic [ALPHABET_SIZE-1:0] letter_bit;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer = in_i.valid && in_i.ready;

  // Out-of-range letters read slot zero of the node; the result is ignored
  assign letter_ok = CmpW'(in_i.payload.letter) < CmpW'(ALPHABET_SIZE);
  assign letter_sel = letter_ok ? in_i.payload.letter : '0;
  assign slot = LinkAw'(cur_q) * LinkAw'(ALPHABET_SIZE) + LinkAw'(letter_sel);

  tie_ram #(
    .Width (NodeWordW),
    .Depth (POOL_NODES)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wdata_i (node_wdata),
    .re_i    (in_xfer),
    .raddr_i (cur_q),
    .rdata_o (node_rdata)
  );

  tie_ram #(
    .Width (NodeW),
    .Depth (LinkDepth)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (slot_q),
    .wdata_i (fresh),
    .re_i    (in_xfer),
    .raddr_i (slot),
    .rdata_o (link_rdata)
  );

  // The root reads as empty until it is first written after reset or clear
  assign node_word = ((cur_q == '0) && !root_valid_q) ? '0 : node_rdata;
  assign fresh = NodeW'(used_q);
  assign letter_bit = ALPHABET_SIZE'(1) << letter_q;
  // Finish the item only when the output register is free or being emptied
  assign exec_go = !out_valid_q || out_o.ready;

  always_comb begin
    state_d = state_q;
    cur_d = cur_q;
    used_d = used_q;
    failed_d = failed_q;
    root_valid_d = root_valid_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_d = out_q;
    node_we = 1'b0;
    node_waddr = cur_q;
    node_wdata = node_word;
    link_we = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          state_d = S_IDLE;
          out_valid_d = 1'b1;
          out_d.created = 1'b0;
          out_d.pool_full = 1'b0;
          out_d.already_word = 1'b0;
          case (kind_q)
            KindLetter: begin
              if (letter_ok_q) begin
                if (failed_q) begin
                  out_d.pool_full = 1'b1;
                end else if ((node_word[ALPHABET_SIZE-1:0] & letter_bit) != '0) begin
                  cur_d = link_rdata;
                end else if (used_q < UsedW'(POOL_NODES)) begin
                  // Link the fresh node in, then clear its entry next cycle
                  node_we = 1'b1;
                  node_wdata = node_word | {1'b0, letter_bit};
                  link_we = 1'b1;
                  if (cur_q == '0) begin
                    root_valid_d = 1'b1;
                  end
                  cur_d = fresh;
                  used_d = used_q + UsedW'(1);
                  out_d.created = 1'b1;
                  state_d = S_INIT;
                end else begin
                  failed_d = 1'b1;
                  out_d.pool_full = 1'b1;
                end
              end
            end
            KindEnd: begin
              if (failed_q) begin
                out_d.pool_full = 1'b1;
              end else begin
                out_d.already_word = node_word[ALPHABET_SIZE];
                node_we = 1'b1;
                node_wdata = node_word | {1'b1, {ALPHABET_SIZE{1'b0}}};
                if (cur_q == '0) begin
                  root_valid_d = 1'b1;
                end
              end
              cur_d = '0;
              failed_d = 1'b0;
            end
            KindClear: begin
              cur_d = '0;
              used_d = UsedW'(1);
              failed_d = 1'b0;
              root_valid_d = 1'b0;
            end
            default: begin
              // Unused kind: report the current node, change nothing
            end
          endcase
          out_d.node_index = NodeIdxW'(cur_d);
        end
      end
      S_INIT: begin
        // Empty the freshly allocated node (now current)
        node_we = 1'b1;
        node_waddr = cur_q;
        node_wdata = '0;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cur_q <= '0;
      used_q <= UsedW'(1);
      failed_q <= 1'b0;
      root_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q <= cur_d;
      used_q <= used_d;
      failed_q <= failed_d;
      root_valid_q <= root_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (in_xfer) begin
      kind_q <= in_i.payload.kind;
      letter_q <= letter_sel;
      letter_ok_q <= letter_ok;
      slot_q <= slot;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.payload = out_q;

`ifndef SYNTHESIS
  // Allocation count stays within the pool and never drops the root
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q != '0) && (used_q <= UsedW'(POOL_NODES)))
    else $error("node count out of range");

  // A word is dropped only when the pool is exhausted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed_q |-> (used_q == UsedW'(POOL_NODES)))
    else $error("word dropped with free nodes left");

  // An allocating letter moves to the fresh node and clears its entry next
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) && exec_go && link_we |=>
      (state_q == S_INIT) && (cur_q == $past(fresh)) && node_we)
    else $error("fresh node not cleared after allocation");

  // A created node never comes with a full flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.created |-> !out_q.pool_full)
    else $error("created and pool_full both set");

  // End and clear items always report the root
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) && exec_go && ((kind_q == KindEnd) || (kind_q == KindClear))
      |=> out_valid_q && (out_q.node_index == '0))
    else $error("end or clear did not return to root");
`endif

endmodule

// ===== hdl/tie_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies; contents are undefined until written.
module tie_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== dv/trie_insert_engine_core_tb.sv =====
// Testbench for trie_insert_engine_core: drives letter, end and clear items into the
// prefix tree engine and checks every result against an in-bench tree predictor.
// Depends on tie_pkg, tie_stream_if and the engine RTL.
module trie_insert_engine_core_tb;
  import tie_pkg::*;

  localparam int unsigned PoolNodes = 1024;
  localparam int unsigned AlphabetSize = 26;
  // The fourth kind code has no meaning; the engine ignores it and reports the current node.
  localparam logic [KindW-1:0] KindSpare = 2'd3;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned MaxReports = 10;

  bit clk_i;
  logic rst_ni = 1'b0;

  tie_stream_if #(.payload_t(tie_in_t)) in_if ();
  tie_stream_if #(.payload_t(tie_out_t)) out_if ();

  trie_insert_engine_core #(
    .POOL_NODES(PoolNodes),
    .ALPHABET_SIZE(AlphabetSize)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_i(in_if),
    .out_o(out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Idle and stall odds in percent, changed per phase by the test sequence.
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;

  // Receiver hold-off: the test bumps hold_req, the ready process counts the stretch.
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;
  int unsigned hold_left = 0;

  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;

  // ---------------------------------------------------------------------------
  // Tree predictor: private copy of the node pool, the cursor and the abandon flag.
  // ---------------------------------------------------------------------------
  logic [AlphabetSize-1:0] kids_mask [PoolNodes];
  logic [NodeIdxW-1:0]     kid_link  [PoolNodes][AlphabetSize];
  logic                    is_word   [PoolNodes];
  int unsigned             used_count;
  int unsigned             cursor;
  bit                      abandoned;

  // Node visits still owed by the engine, oldest first.
  tie_out_t visit_q [$];

  function automatic void clear_tree();
    kids_mask[0] = '0;
    is_word[0] = 1'b0;
    used_count = 1;
    cursor = 0;
    abandoned = 1'b0;
  endfunction

  // Random letter field value in the given range.
  function automatic logic [LetterW-1:0] rand_letter(int unsigned lo, int unsigned hi);
    return LetterW'($urandom_range(hi, lo));
  endfunction

  // Apply one item to the tree and return the node visit it should produce.
  function automatic tie_out_t walk_tree(tie_in_t item);
    tie_out_t res;
    res = '0;
    case (item.kind)
      KindLetter: begin
        // Letters past the alphabet are dropped without touching anything.
        if (item.letter < AlphabetSize) begin
          if (abandoned) begin
            res.pool_full = 1'b1;
          end else if (kids_mask[cursor][item.letter]) begin
            cursor = 32'(kid_link[cursor][item.letter]);
          end else if (used_count < PoolNodes) begin
            // Take the next pool node, empty it and hang it under the cursor.
            kids_mask[used_count] = '0;
            is_word[used_count] = 1'b0;
            kids_mask[cursor][item.letter] = 1'b1;
            kid_link[cursor][item.letter] = used_count[NodeIdxW-1:0];
            cursor = used_count;
            used_count++;
            res.created = 1'b1;
          end else begin
            abandoned = 1'b1;
            res.pool_full = 1'b1;
          end
        end
      end
      KindEnd: begin
        // An abandoned word is never marked; either way go back to the root.
        if (abandoned) begin
          res.pool_full = 1'b1;
        end else begin
          res.already_word = is_word[cursor];
          is_word[cursor] = 1'b1;
        end
        cursor = 0;
        abandoned = 1'b0;
      end
      KindClear: clear_tree();
      default: ;
    endcase
    res.node_index = cursor[NodeIdxW-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: offer one item from a falling edge and hold it until the transfer.
  // Valid is left high on return so back-to-back items never toggle it in one step.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [KindW-1:0] kind, input logic [LetterW-1:0] letter);
    tie_in_t item;
    item.kind = kind;
    item.letter = letter;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.payload <= item;
    do @(posedge clk_i); while (!in_if.ready);
    visit_q.push_back(walk_tree(item));
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, or a long hold-off when the test asks for one.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HoldCycles;
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  function automatic void flag_mismatch(string what, tie_out_t exp_v, tie_out_t got_v);
    mismatch_count++;
    if (mismatch_count <= MaxReports) begin
      $display("%0t: %s: expected node %0d created %0b full %0b already %0b,",
               $time, what, exp_v.node_index, exp_v.created, exp_v.pool_full,
               exp_v.already_word,
               " got node %0d created %0b full %0b already %0b",
               got_v.node_index, got_v.created, got_v.pool_full, got_v.already_word);
    end
  endfunction

  // Check each result transfer against the oldest owed visit.
  always @(posedge clk_i) begin
    tie_out_t got_v;
    tie_out_t exp_v;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got_v = out_if.payload;
      if (visit_q.size() == 0) begin
        flag_mismatch("result with nothing owed", '0, got_v);
      end else begin
        exp_v = visit_q.pop_front();
        if (got_v.node_index !== exp_v.node_index || got_v.created !== exp_v.created ||
            got_v.pool_full !== exp_v.pool_full ||
            got_v.already_word !== exp_v.already_word) begin
          flag_mismatch("node visit mismatch", exp_v, got_v);
        end
      end
    end
  end

  // Watchdog: count cycles with no transfer on either side.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= StallLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Short walk over the field extremes and every kind of item.
  task automatic test_directed();
    send_item(KindClear, 5'd31);
    send_item(KindLetter, 5'd0);          // creates the first node
    send_item(KindLetter, 5'd25);
    send_item(KindEnd, 5'd0);
    send_item(KindLetter, 5'd0);          // same word again follows the links
    send_item(KindLetter, 5'd25);
    send_item(KindEnd, 5'd31);            // already a word end
    send_item(KindEnd, 5'd0);             // empty word marks the root
    send_item(KindEnd, 5'd0);             // and now the root is already marked
    send_item(KindLetter, 5'd16);
    send_item(KindLetter, 5'd26);         // past z: dropped
    send_item(KindLetter, 5'd15);
    send_item(KindSpare, 5'd31);          // spare kind: dropped
    send_item(KindLetter, 5'd31);
    send_item(KindEnd, 5'd16);
    send_item(KindClear, 5'd0);
    send_item(KindEnd, 5'd0);             // root mark was cleared
    send_item(KindLetter, 5'd7);
    send_item(KindClear, 5'd21);          // clear in the middle of a word
    send_item(KindLetter, 5'd7);
    send_item(KindLetter, 5'd7);
    send_item(KindEnd, 5'd10);
  endtask

  // Grow one chain until the pool runs dry, then probe the abandoned-word paths.
  task automatic test_pool_exhaustion();
    logic [LetterW-1:0] chain [$];
    logic [LetterW-1:0] pick;
    send_item(KindClear, rand_letter(0, 31));
    repeat (PoolNodes - 1) begin
      pick = rand_letter(0, AlphabetSize - 1);
      chain.push_back(pick);
      send_item(KindLetter, pick);
    end
    send_item(KindLetter, rand_letter(0, AlphabetSize - 1));  // no node left
    send_item(KindLetter, rand_letter(0, AlphabetSize - 1));  // word abandoned
    send_item(KindSpare, rand_letter(0, 31));
    send_item(KindLetter, 5'd30);
    send_item(KindEnd, rand_letter(0, 31));                   // closes abandoned word
    // Existing links still work with a full pool.
    for (int i = 0; i < 5; i++) send_item(KindLetter, chain[i]);
    send_item(KindEnd, rand_letter(0, 31));
    send_item(KindLetter, LetterW'((chain[0] + 1) % AlphabetSize));  // new branch at root
    send_item(KindEnd, rand_letter(0, 31));
    send_item(KindEnd, rand_letter(0, 31));
  endtask

  // Hold the receiver off while items keep coming so the engine stalls its input.
  task automatic test_backpressure();
    send_item(KindClear, rand_letter(0, 31));
    hold_req++;
    repeat (10) begin
      repeat ($urandom_range(1, 5)) send_item(KindLetter, rand_letter(0, 3));
      send_item(KindEnd, rand_letter(0, 31));
    end
  endtask

  // Random words with random content, some replayed, some broken, plus noise.
  task automatic test_random_words(input int unsigned target);
    logic [LetterW-1:0] word [$];
    int unsigned sent;
    int unsigned pick;
    int unsigned len;
    bit narrow;
    sent = 0;
    while (sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        send_item(KindClear, rand_letter(0, 31));
        sent++;
      end else if (pick < 8) begin
        // Ignored items do not count toward the target.
        if (pick[0]) send_item(KindSpare, rand_letter(0, 31));
        else send_item(KindLetter, rand_letter(AlphabetSize, 31));
      end else if (pick < 20 && word.size() != 0) begin
        // Replay the last word to land on a node already marked.
        foreach (word[i]) send_item(KindLetter, word[i]);
        send_item(KindEnd, rand_letter(0, 31));
        sent += word.size() + 1;
      end else begin
        // A narrow alphabet makes prefixes collide so links get followed.
        narrow = 1'($urandom_range(0, 1));
        len = $urandom_range(0, 10);
        word.delete();
        repeat (len) begin
          word.push_back(narrow ? rand_letter(0, 3) : rand_letter(0, AlphabetSize - 1));
        end
        foreach (word[i]) begin
          if ($urandom_range(0, 29) == 0) send_item(KindSpare, rand_letter(0, 31));
          send_item(KindLetter, word[i]);
        end
        if ($urandom_range(0, 19) == 0) send_item(KindClear, rand_letter(0, 31));
        else send_item(KindEnd, rand_letter(0, 31));
        sent += len + 1;
      end
    end
  endtask

  initial begin
    in_if.valid <= 1'b0;
    in_if.payload <= '0;
    clear_tree();
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_pool_exhaustion();
    test_backpressure();

    // Random part across the idle phases.
    test_random_words(125);
    tx_idle_pct = 47;
    test_random_words(125);
    tx_idle_pct = 0;
    rx_stall_pct = 47;
    test_random_words(125);
    tx_idle_pct = 6;
    rx_stall_pct = 6;
    test_random_words(125);
    in_if.valid <= 1'b0;

    // Drain; the watchdog bounds the wait, then allow for stray late results.
    while (visit_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
